### hw/rtl/chr_pkg.sv
`default_nettype none
package chr_pkg;

    localparam int RING_DEPTH_DEF   = 256;
    localparam int NODE_ID_BITS_DEF = 16;
    localparam int HASH_W           = 32;
    localparam int ID_DIGITS        = 10;
    localparam int REP_DIGITS       = 3;

    // positions in the text table: "node-" then "-rep-"
    localparam logic [3:0] TXT_NODE_FIRST = 4'd0;
    localparam logic [3:0] TXT_NODE_LAST  = 4'd4;
    localparam logic [3:0] TXT_REP_FIRST  = 4'd5;
    localparam logic [3:0] TXT_REP_LAST   = 4'd9;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_KEY    = 3'd2,
        CMD_QUERY  = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd_code;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_REPS  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {SRC_TEXT, SRC_ID, SRC_REP} t_src;
    typedef enum logic [1:0] {EH_HOLD, EH_CLR, EH_MIX} t_eh_op;
    typedef enum logic [2:0] {K_HOLD, K_CLR, K_LOAD, K_INC, K_DEC} t_k_op;
    typedef enum logic [1:0] {W_HOLD, W_CLR, W_INC} t_w_op;
    typedef enum logic [1:0] {C_HOLD, C_CLR, C_INC, C_LOAD_W} t_cnt_op;
    typedef enum logic [1:0] {RD_NONE, RD_K, RD_KM1} t_rd_op;
    typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_NEW, WR_KEEP} t_wr_op;
    typedef enum logic [1:0] {OS_NONE, OS_FIRST, OS_RD, OS_QUERY} t_osel;

    typedef struct packed {
        logic       in_take;
        logic       key_mix;
        logic       acc_clr;
        t_eh_op     eh_op;
        t_src       src;
        logic [3:0] idx;
        t_k_op      k_op;
        t_w_op      w_op;
        t_cnt_op    cnt_op;
        t_rd_op     rd_op;
        t_wr_op     wr_op;
        logic       rep_inc;
        logic       dab_step;
        logic       first_save;
        logic       out_load;
        t_osel      out_sel;
        t_status    out_status;
    } t_ctl;

    typedef struct packed {
        logic rd_gt;
        logic rd_ge_key;
        logic rd_node_eq;
        logic k_zero;
        logic k_eq_cnt;
        logic w_eq_cnt;
        logic cnt_zero;
        logic full;
        logic reps_zero;
        logic rep_done;
        logic dab_done;
        logic dig_zero;
    } t_st;

    function automatic logic [7:0] text_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h6E;
            4'd1:    b = 8'h6F;
            4'd2:    b = 8'h64;
            4'd3:    b = 8'h65;
            4'd4:    b = 8'h2D;
            4'd5:    b = 8'h2D;
            4'd6:    b = 8'h72;
            4'd7:    b = 8'h65;
            4'd8:    b = 8'h70;
            default: b = 8'h2D;
        endcase
        return b;
    endfunction

    // h * 31 + b
    function automatic logic [HASH_W-1:0] mix(input logic [HASH_W-1:0] h,
                                              input logic [7:0] b);
        return (h << 5) - h + HASH_W'(b);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/chr_in_if.sv
`default_nettype none
interface chr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] node_id;
    logic [8:0]  replicas;
    logic [7:0]  key_byte;
    logic        byte_present;
    logic        key_last;

    modport source (output valid, cmd, node_id, replicas, key_byte, byte_present, key_last,
                    input ready);
    modport sink (input valid, cmd, node_id, replicas, key_byte, byte_present, key_last,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/chr_out_if.sv
`default_nettype none
interface chr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] found_node;
    logic [8:0]  replica_count;
    logic        node_exists;

    modport source (output valid, status, found_node, replica_count, node_exists,
                    input ready);
    modport sink (input valid, status, found_node, replica_count, node_exists,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/chr_dp.sv
`default_nettype none
module chr_dp #(
    parameter int RING_DEPTH   = chr_pkg::RING_DEPTH_DEF,
    parameter int NODE_ID_BITS = chr_pkg::NODE_ID_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire chr_pkg::t_ctl i_ctl,
    output chr_pkg::t_st       o_st,
    input  wire logic [15:0]   i_node_id,
    input  wire logic [8:0]    i_replicas,
    input  wire logic [7:0]    i_key_byte,
    output logic [2:0]         o_status,
    output logic [15:0]        o_found_node,
    output logic [8:0]         o_replica_count,
    output logic               o_node_exists
);
    localparam int HW    = chr_pkg::HASH_W;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RW    = (CNT_W > 9) ? CNT_W : 9;
    localparam int SW    = RW + 1;
    localparam int BD    = chr_pkg::ID_DIGITS * 4;
    localparam int DB_W  = $clog2(NODE_ID_BITS + 1);

    logic [HW-1:0]           m_hash [RING_DEPTH];
    logic [NODE_ID_BITS-1:0] m_node [RING_DEPTH];

    logic [HW-1:0]           r_rd_hash;
    logic [NODE_ID_BITS-1:0] r_rd_node;
    logic [NODE_ID_BITS-1:0] r_first;
    logic [NODE_ID_BITS-1:0] r_id;
    logic [8:0]              r_reps;
    logic [8:0]              r_rep;
    logic [3:0]              r_rbcd [chr_pkg::REP_DIGITS];
    logic [BD-1:0]           r_bcd;
    logic [NODE_ID_BITS-1:0] r_sh;
    logic [DB_W-1:0]         r_dab;
    logic [HW-1:0]           r_acc;
    logic [HW-1:0]           r_eh;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        r_k;
    logic [CNT_W-1:0]        r_w;
    logic [2:0]              r_o_status;
    logic [15:0]             r_o_found;
    logic [8:0]              r_o_rcount;
    logic                    r_o_exists;

    logic [7:0]       mix_b;
    logic [3:0]       dig;
    logic [BD-1:0]    bcd_adj;
    logic [CNT_W-1:0] km1;
    logic [SW-1:0]    fill_sum;
    logic [RW-1:0]    w_ext;
    logic [3:0]       id_dig [chr_pkg::ID_DIGITS];

    always_comb begin
        for (int d = 0; d < chr_pkg::ID_DIGITS; d++) begin
            id_dig[d] = r_bcd[d*4 +: 4];
            bcd_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                            : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        unique case (i_ctl.src)
            chr_pkg::SRC_TEXT: dig = 4'd1;
            chr_pkg::SRC_ID:   dig = id_dig[i_ctl.idx];
            chr_pkg::SRC_REP:  dig = r_rbcd[i_ctl.idx[1:0]];
            default:           dig = 4'd1;
        endcase
        mix_b = (i_ctl.src == chr_pkg::SRC_TEXT) ? chr_pkg::text_byte(i_ctl.idx)
                                                 : {4'h3, dig};
    end

    assign km1      = r_k - CNT_W'(1);
    assign fill_sum = SW'(r_cnt) + SW'(r_reps);
    assign w_ext    = RW'(r_w);

    always_comb begin
        o_st.rd_gt      = r_rd_hash > r_eh;
        o_st.rd_ge_key  = r_rd_hash >= r_acc;
        o_st.rd_node_eq = r_rd_node == r_id;
        o_st.k_zero     = r_k == '0;
        o_st.k_eq_cnt   = r_k == r_cnt;
        o_st.w_eq_cnt   = r_w == r_cnt;
        o_st.cnt_zero   = r_cnt == '0;
        o_st.full       = fill_sum > SW'(RING_DEPTH);
        o_st.reps_zero  = r_reps == '0;
        o_st.rep_done   = r_rep == r_reps;
        o_st.dab_done   = r_dab == DB_W'(NODE_ID_BITS);
        o_st.dig_zero   = (i_ctl.src != chr_pkg::SRC_TEXT) && (dig == 4'd0);
    end

    // entry store
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.wr_op)
            chr_pkg::WR_SHIFT: begin
                m_hash[r_k[AW-1:0]] <= r_rd_hash;
                m_node[r_k[AW-1:0]] <= r_rd_node;
            end
            chr_pkg::WR_NEW: begin
                m_hash[r_k[AW-1:0]] <= r_eh;
                m_node[r_k[AW-1:0]] <= r_id;
            end
            chr_pkg::WR_KEEP: begin
                m_hash[r_w[AW-1:0]] <= r_rd_hash;
                m_node[r_w[AW-1:0]] <= r_rd_node;
            end
            default: ;
        endcase
        unique case (i_ctl.rd_op)
            chr_pkg::RD_K: begin
                r_rd_hash <= m_hash[r_k[AW-1:0]];
                r_rd_node <= m_node[r_k[AW-1:0]];
            end
            chr_pkg::RD_KM1: begin
                r_rd_hash <= m_hash[km1[AW-1:0]];
                r_rd_node <= m_node[km1[AW-1:0]];
            end
            default: ;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.in_take) begin
            r_id   <= NODE_ID_BITS'(i_node_id);
            r_reps <= i_replicas;
            r_rep  <= '0;
            for (int d = 0; d < chr_pkg::REP_DIGITS; d++) r_rbcd[d] <= 4'd0;
            r_bcd  <= '0;
            r_sh   <= NODE_ID_BITS'(i_node_id);
            r_dab  <= '0;
        end else begin
            if (i_ctl.dab_step) begin
                r_bcd <= {bcd_adj[BD-2:0], r_sh[NODE_ID_BITS-1]};
                r_sh  <= r_sh << 1;
                r_dab <= r_dab + DB_W'(1);
            end
            if (i_ctl.rep_inc) begin
                r_rep <= r_rep + 9'd1;
                if (r_rbcd[0] != 4'd9) begin
                    r_rbcd[0] <= r_rbcd[0] + 4'd1;
                end else begin
                    r_rbcd[0] <= 4'd0;
                    if (r_rbcd[1] != 4'd9) begin
                        r_rbcd[1] <= r_rbcd[1] + 4'd1;
                    end else begin
                        r_rbcd[1] <= 4'd0;
                        r_rbcd[2] <= r_rbcd[2] + 4'd1;
                    end
                end
            end
        end
        unique case (i_ctl.eh_op)
            chr_pkg::EH_CLR: r_eh <= '0;
            chr_pkg::EH_MIX: r_eh <= chr_pkg::mix(r_eh, mix_b);
            default: ;
        endcase
        if (i_ctl.first_save) r_first <= r_rd_node;
        if (i_ctl.out_load) begin
            r_o_status <= i_ctl.out_status;
            unique case (i_ctl.out_sel)
                chr_pkg::OS_FIRST: r_o_found <= 16'(r_first);
                chr_pkg::OS_RD:    r_o_found <= 16'(r_rd_node);
                default:           r_o_found <= '0;
            endcase
            if (i_ctl.out_sel == chr_pkg::OS_QUERY) begin
                r_o_rcount <= (w_ext > RW'(511)) ? 9'd511 : 9'(r_w);
                r_o_exists <= r_w != '0;
            end else begin
                r_o_rcount <= '0;
                r_o_exists <= 1'b0;
            end
        end
    end

    // control counters and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_k   <= '0;
            r_w   <= '0;
        end else begin
            if (i_ctl.acc_clr) begin
                r_acc <= '0;
            end else if (i_ctl.key_mix) begin
                r_acc <= chr_pkg::mix(r_acc, i_key_byte);
            end
            unique case (i_ctl.cnt_op)
                chr_pkg::C_CLR:    r_cnt <= '0;
                chr_pkg::C_INC:    r_cnt <= r_cnt + CNT_W'(1);
                chr_pkg::C_LOAD_W: r_cnt <= r_w;
                default: ;
            endcase
            unique case (i_ctl.k_op)
                chr_pkg::K_CLR:  r_k <= '0;
                chr_pkg::K_LOAD: r_k <= r_cnt;
                chr_pkg::K_INC:  r_k <= r_k + CNT_W'(1);
                chr_pkg::K_DEC:  r_k <= km1;
                default: ;
            endcase
            unique case (i_ctl.w_op)
                chr_pkg::W_CLR: r_w <= '0;
                chr_pkg::W_INC: r_w <= r_w + CNT_W'(1);
                default: ;
            endcase
        end
    end

    assign o_status        = r_o_status;
    assign o_found_node    = r_o_found;
    assign o_replica_count = r_o_rcount;
    assign o_node_exists   = r_o_exists;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RING_DEPTH))
        else $error("entry count beyond ring depth");
    a_new_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.wr_op == chr_pkg::WR_NEW) |-> (r_cnt < CNT_W'(RING_DEPTH)))
        else $error("insert into a full ring");
    a_w_behind_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w <= r_k)
        else $error("compaction write pointer ahead of scan");
`endif
endmodule
`default_nettype wire

### hw/rtl/chr_ctrl.sv
`default_nettype none
module chr_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [2:0]   i_cmd,
    input  wire logic         i_byte_present,
    input  wire logic         i_key_last,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output chr_pkg::t_ctl     o_ctl,
    input  wire chr_pkg::t_st i_st
);
    typedef enum logic [4:0] {
        S_IDLE, S_ADD_CHK, S_DAB, S_R_START, S_TXT1, S_IDD, S_TXT2, S_RPD,
        S_INS_START, S_INS_CHK, S_INS_CMP, S_RM_RD, S_RM_CMP, S_QY_RD, S_QY_CMP,
        S_LK_RD, S_LK_CMP, S_RESP
    } t_state;

    t_state            r_state, n_state;
    logic [3:0]        r_idx, n_idx;
    logic              r_started, n_started;
    chr_pkg::t_status  r_status, n_status;
    chr_pkg::t_osel    r_sel, n_sel;
    logic              r_ovalid;
    logic              take;
    logic              out_free;
    logic              dig_use;

    assign o_in_ready = r_state == S_IDLE;
    assign take       = i_in_valid && o_in_ready;
    assign out_free   = !r_ovalid || i_out_ready;
    // skip leading zeros, but always emit the units digit
    assign dig_use    = !(i_st.dig_zero && !r_started && r_idx != 4'd0);

    always_comb begin
        o_ctl            = '0;
        o_ctl.eh_op      = chr_pkg::EH_HOLD;
        o_ctl.src        = chr_pkg::SRC_TEXT;
        o_ctl.idx        = r_idx;
        o_ctl.k_op       = chr_pkg::K_HOLD;
        o_ctl.w_op       = chr_pkg::W_HOLD;
        o_ctl.cnt_op     = chr_pkg::C_HOLD;
        o_ctl.rd_op      = chr_pkg::RD_NONE;
        o_ctl.wr_op      = chr_pkg::WR_NONE;
        o_ctl.out_sel    = r_sel;
        o_ctl.out_status = r_status;
        n_state   = r_state;
        n_idx     = r_idx;
        n_started = r_started;
        n_status  = r_status;
        n_sel     = r_sel;
        unique case (r_state)
            S_IDLE: if (take) begin
                o_ctl.in_take = 1'b1;
                o_ctl.k_op    = chr_pkg::K_CLR;
                o_ctl.w_op    = chr_pkg::W_CLR;
                unique case (i_cmd)
                    chr_pkg::CMD_ADD:    n_state = S_ADD_CHK;
                    chr_pkg::CMD_REMOVE: n_state = S_RM_RD;
                    chr_pkg::CMD_QUERY:  n_state = S_QY_RD;
                    chr_pkg::CMD_KEY: begin
                        o_ctl.key_mix = i_byte_present;
                        if (i_key_last) n_state = S_LK_RD;
                    end
                    chr_pkg::CMD_CLEAR: begin
                        o_ctl.cnt_op = chr_pkg::C_CLR;
                        n_status = chr_pkg::ST_OK;
                        n_sel    = chr_pkg::OS_NONE;
                        n_state  = S_RESP;
                    end
                    default: ;
                endcase
            end
            S_ADD_CHK: begin
                n_sel   = chr_pkg::OS_NONE;
                n_state = S_RESP;
                if (i_st.reps_zero) begin
                    n_status = chr_pkg::ST_BAD_REPS;
                end else if (i_st.full) begin
                    n_status = chr_pkg::ST_FULL;
                end else begin
                    n_status = chr_pkg::ST_OK;
                    n_state  = S_DAB;
                end
            end
            S_DAB: begin
                if (i_st.dab_done) n_state = S_R_START;
                else o_ctl.dab_step = 1'b1;
            end
            S_R_START: begin
                if (i_st.rep_done) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.eh_op = chr_pkg::EH_CLR;
                    n_idx   = chr_pkg::TXT_NODE_FIRST;
                    n_state = S_TXT1;
                end
            end
            S_TXT1: begin
                o_ctl.eh_op = chr_pkg::EH_MIX;
                if (r_idx == chr_pkg::TXT_NODE_LAST) begin
                    n_idx     = 4'(chr_pkg::ID_DIGITS - 1);
                    n_started = 1'b0;
                    n_state   = S_IDD;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_IDD: begin
                o_ctl.src = chr_pkg::SRC_ID;
                if (dig_use) begin
                    o_ctl.eh_op = chr_pkg::EH_MIX;
                    n_started   = 1'b1;
                end
                if (r_idx == 4'd0) begin
                    n_idx   = chr_pkg::TXT_REP_FIRST;
                    n_state = S_TXT2;
                end else begin
                    n_idx = r_idx - 4'd1;
                end
            end
            S_TXT2: begin
                o_ctl.eh_op = chr_pkg::EH_MIX;
                if (r_idx == chr_pkg::TXT_REP_LAST) begin
                    n_idx     = 4'(chr_pkg::REP_DIGITS - 1);
                    n_started = 1'b0;
                    n_state   = S_RPD;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_RPD: begin
                o_ctl.src = chr_pkg::SRC_REP;
                if (dig_use) begin
                    o_ctl.eh_op = chr_pkg::EH_MIX;
                    n_started   = 1'b1;
                end
                if (r_idx == 4'd0) n_state = S_INS_START;
                else n_idx = r_idx - 4'd1;
            end
            S_INS_START: begin
                o_ctl.k_op = chr_pkg::K_LOAD;
                n_state    = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (i_st.k_zero) begin
                    o_ctl.wr_op   = chr_pkg::WR_NEW;
                    o_ctl.cnt_op  = chr_pkg::C_INC;
                    o_ctl.rep_inc = 1'b1;
                    n_state = S_R_START;
                end else begin
                    o_ctl.rd_op = chr_pkg::RD_KM1;
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                // move larger entries up one slot, insert after equal hashes
                if (i_st.rd_gt) begin
                    o_ctl.wr_op = chr_pkg::WR_SHIFT;
                    o_ctl.k_op  = chr_pkg::K_DEC;
                    n_state = S_INS_CHK;
                end else begin
                    o_ctl.wr_op   = chr_pkg::WR_NEW;
                    o_ctl.cnt_op  = chr_pkg::C_INC;
                    o_ctl.rep_inc = 1'b1;
                    n_state = S_R_START;
                end
            end
            S_RM_RD: begin
                if (i_st.k_eq_cnt) begin
                    o_ctl.cnt_op = chr_pkg::C_LOAD_W;
                    n_status = i_st.w_eq_cnt ? chr_pkg::ST_NOT_FOUND : chr_pkg::ST_OK;
                    n_sel    = chr_pkg::OS_NONE;
                    n_state  = S_RESP;
                end else begin
                    o_ctl.rd_op = chr_pkg::RD_K;
                    n_state = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                if (!i_st.rd_node_eq) begin
                    o_ctl.wr_op = chr_pkg::WR_KEEP;
                    o_ctl.w_op  = chr_pkg::W_INC;
                end
                o_ctl.k_op = chr_pkg::K_INC;
                n_state = S_RM_RD;
            end
            S_QY_RD: begin
                if (i_st.k_eq_cnt) begin
                    n_status = chr_pkg::ST_OK;
                    n_sel    = chr_pkg::OS_QUERY;
                    n_state  = S_RESP;
                end else begin
                    o_ctl.rd_op = chr_pkg::RD_K;
                    n_state = S_QY_CMP;
                end
            end
            S_QY_CMP: begin
                if (i_st.rd_node_eq) o_ctl.w_op = chr_pkg::W_INC;
                o_ctl.k_op = chr_pkg::K_INC;
                n_state = S_QY_RD;
            end
            S_LK_RD: begin
                if (i_st.cnt_zero) begin
                    o_ctl.acc_clr = 1'b1;
                    n_status = chr_pkg::ST_EMPTY;
                    n_sel    = chr_pkg::OS_NONE;
                    n_state  = S_RESP;
                end else if (i_st.k_eq_cnt) begin
                    // no hash at or above the key: wrap to the first entry
                    o_ctl.acc_clr = 1'b1;
                    n_status = chr_pkg::ST_OK;
                    n_sel    = chr_pkg::OS_FIRST;
                    n_state  = S_RESP;
                end else begin
                    o_ctl.rd_op = chr_pkg::RD_K;
                    n_state = S_LK_CMP;
                end
            end
            S_LK_CMP: begin
                o_ctl.first_save = i_st.k_zero;
                if (i_st.rd_ge_key) begin
                    o_ctl.acc_clr = 1'b1;
                    n_status = chr_pkg::ST_OK;
                    n_sel    = chr_pkg::OS_RD;
                    n_state  = S_RESP;
                end else begin
                    o_ctl.k_op = chr_pkg::K_INC;
                    n_state = S_LK_RD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_started <= 1'b0;
            r_status  <= chr_pkg::ST_OK;
            r_sel     <= chr_pkg::OS_NONE;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_started <= n_started;
            r_status  <= n_status;
            r_sel     <= n_sel;
            if (o_ctl.out_load) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid = r_ovalid;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_load |-> (!r_ovalid || i_out_ready))
        else $error("result register overwritten before transfer");
    a_resp_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && out_free) |=> r_ovalid)
        else $error("pending result not presented");
    a_drop_on_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ovalid) |-> $past(i_out_ready))
        else $error("result dropped without transfer");
`endif
endmodule
`default_nettype wire

### hw/rtl/consistent_hash_ring.sv
`default_nettype none
// Consistent hash ring with virtual nodes.
// i_in carries commands: add node, remove node, key byte, replica query, clear.
// o_out carries one result per command; key bytes that are not last give none.
// Input ready is high only while the controller is idle. A key byte that is not
// last leaves the controller idle, so a key streams at one byte per cycle.
// Add: decimal conversion of the node id, then per replica the hashing of its
// name and the placing of its entry, with each larger entry moved up one slot,
// then the result. Remove and query: a walk over every ring entry. Lookup: a
// linear walk over the sorted ring up to the first hash at or above the key,
// wrapping to the first entry when there is none. The walks are set by the
// single read port of the entry store, whose read is registered before each
// compare.
// Results sit in an output register; while the receiver stalls a key byte that
// is not last is still taken, anything else waits in the controller.
// Reset empties the ring and the key accumulator at once; stored entries are
// not cleared, only those below the entry count are ever read.
module consistent_hash_ring #(
    parameter int RING_DEPTH   = chr_pkg::RING_DEPTH_DEF,
    parameter int NODE_ID_BITS = chr_pkg::NODE_ID_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    chr_in_if.sink     i_in,
    chr_out_if.source  o_out
);
    chr_pkg::t_ctl ctl;
    chr_pkg::t_st  st;
    logic          in_ready;
    logic          out_valid;

    chr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (in_ready),
        .i_cmd          (i_in.cmd),
        .i_byte_present (i_in.byte_present),
        .i_key_last     (i_in.key_last),
        .o_out_valid    (out_valid),
        .i_out_ready    (o_out.ready),
        .o_ctl          (ctl),
        .i_st           (st)
    );

    chr_dp #(
        .RING_DEPTH   (RING_DEPTH),
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_st            (st),
        .i_node_id       (i_in.node_id),
        .i_replicas      (i_in.replicas),
        .i_key_byte      (i_in.key_byte),
        .o_status        (o_out.status),
        .o_found_node    (o_out.found_node),
        .o_replica_count (o_out.replica_count),
        .o_node_exists   (o_out.node_exists)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
endmodule
`default_nettype wire
